// ===== rtl/cco_pkg.sv =====
// ---------------------------------------------------------------------------
// cco_pkg
// shared types and constants for the culled circle overlap pair finder
// ---------------------------------------------------------------------------
package cco_pkg;

    localparam int COORD_W = 24;
    localparam int RAD_W   = 16;
    localparam int IDX_W   = 16;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_VIEW_MIN_X = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_VIEW_MAX_X = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_VIEW_MIN_Y = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_VIEW_MAX_Y = 2'd3;

    localparam logic PAIR_OBJECT   = 1'b0;
    localparam logic PAIR_PARTICLE = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the request and update counts
        logic rd_obj;    // read object entry at scan index
        logic rd_part;   // read particle entry at scan index
        logic scan_clr;  // reset scan index
        logic scan_inc;  // advance scan index
        logic store;     // write arriving object into the store
        logic test;      // compare registered entry against request
    } cco_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic keep_obj;   // request is an object, kept, with room
        logic obj_done;   // scan index reached object count
        logic part_done;  // scan index reached particle count
    } cco_stat_t;

endpackage

// ===== rtl/cco_datapath.sv =====
// ---------------------------------------------------------------------------
// cco_datapath
// circle stores, culling, squared distance compare and the pair buffer
// ---------------------------------------------------------------------------
module cco_datapath #(
    parameter int OBJECT_SLOTS   = 32,
    parameter int PARTICLE_SLOTS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cco_pkg::cco_cmd_t                  cmd,
    output cco_pkg::cco_stat_t                 stat,
    input  logic                               cfg_we,
    input  logic [cco_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic signed [cco_pkg::COORD_W-1:0] cfg_data,
    input  logic                               in_start_frame,
    input  logic                               in_kind,
    input  logic [cco_pkg::IDX_W-1:0]          in_index,
    input  logic signed [cco_pkg::COORD_W-1:0] in_x,
    input  logic signed [cco_pkg::COORD_W-1:0] in_y,
    input  logic [cco_pkg::RAD_W-1:0]          in_r,
    output logic                               hit,
    output logic                               hit_kind,
    output logic [cco_pkg::IDX_W-1:0]          hit_first,
    output logic [cco_pkg::IDX_W-1:0]          hit_second
);
    import cco_pkg::*;

    localparam int OA = (OBJECT_SLOTS > 1) ? $clog2(OBJECT_SLOTS) : 1;
    localparam int PA = (PARTICLE_SLOTS > 1) ? $clog2(PARTICLE_SLOTS) : 1;
    localparam int OC = $clog2(OBJECT_SLOTS + 1);
    localparam int PC = $clog2(PARTICLE_SLOTS + 1);
    localparam int SW = (OC > PC) ? OC : PC;

    logic signed [COORD_W-1:0] vmin_x_reg, vmax_x_reg, vmin_y_reg, vmax_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vmin_x_reg <= {1'b1, {(COORD_W-1){1'b0}}};
            vmax_x_reg <= {1'b0, {(COORD_W-1){1'b1}}};
            vmin_y_reg <= {1'b1, {(COORD_W-1){1'b0}}};
            vmax_y_reg <= {1'b0, {(COORD_W-1){1'b1}}};
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_VIEW_MIN_X: vmin_x_reg <= cfg_data;
                REG_VIEW_MAX_X: vmax_x_reg <= cfg_data;
                REG_VIEW_MIN_Y: vmin_y_reg <= cfg_data;
                REG_VIEW_MAX_Y: vmax_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // request registers
    logic signed [COORD_W-1:0] req_x_reg, req_y_reg;
    logic [RAD_W-1:0]          req_r_reg;
    logic [IDX_W-1:0]          req_id_reg;
    logic [OC-1:0]             obj_cnt_reg;
    logic [PC-1:0]             part_cnt_reg;
    logic [SW-1:0]             scan_reg;
    logic                      keep_obj_reg;

    logic [OC-1:0] obj_cnt_base;
    logic [PC-1:0] part_cnt_base;
    logic          in_view;

    assign obj_cnt_base  = in_start_frame ? '0 : obj_cnt_reg;
    assign part_cnt_base = in_start_frame ? '0 : part_cnt_reg;
    assign in_view = (in_x >= vmin_x_reg) && (in_x <= vmax_x_reg) &&
                     (in_y >= vmin_y_reg) && (in_y <= vmax_y_reg);

    logic part_store;
    assign part_store = cmd.load && in_view && in_kind &&
                        (part_cnt_base < PC'(PARTICLE_SLOTS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obj_cnt_reg  <= '0;
            part_cnt_reg <= '0;
            keep_obj_reg <= 1'b0;
            scan_reg     <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                obj_cnt_reg  <= obj_cnt_base;
                part_cnt_reg <= part_cnt_base + PC'(part_store);
                keep_obj_reg <= in_view && !in_kind &&
                                (obj_cnt_base < OC'(OBJECT_SLOTS));
            end
            else if (cmd.store)
            begin
                obj_cnt_reg  <= obj_cnt_reg + OC'(1);
                keep_obj_reg <= 1'b0;
            end
            if (cmd.scan_clr)
                scan_reg <= '0;
            else if (cmd.scan_inc)
                scan_reg <= scan_reg + SW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_x_reg  <= in_x;
            req_y_reg  <= in_y;
            req_r_reg  <= in_r;
            req_id_reg <= in_index;
        end
    end

    assign stat.keep_obj  = keep_obj_reg;
    assign stat.obj_done  = (SW'(obj_cnt_reg) == scan_reg);
    assign stat.part_done = (SW'(part_cnt_reg) == scan_reg);

    // stores: {x, y, r, id}
    localparam int EW = 2*COORD_W + RAD_W + IDX_W;
    logic [EW-1:0] obj_mem  [OBJECT_SLOTS];
    logic [EW-1:0] part_mem [PARTICLE_SLOTS];
    logic [EW-1:0] rd_reg;
    logic          rd_kind_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.store)
            obj_mem[obj_cnt_reg[OA-1:0]] <= {req_x_reg, req_y_reg, req_r_reg, req_id_reg};
        if (part_store)
            part_mem[part_cnt_base[PA-1:0]] <= {in_x, in_y, in_r, in_index};
        if (cmd.rd_obj)
        begin
            rd_reg      <= obj_mem[scan_reg[OA-1:0]];
            rd_kind_reg <= PAIR_OBJECT;
        end
        else if (cmd.rd_part)
        begin
            rd_reg      <= part_mem[scan_reg[PA-1:0]];
            rd_kind_reg <= PAIR_PARTICLE;
        end
    end

    // stage 1: differences and radius sum
    logic signed [COORD_W-1:0] e_x, e_y;
    logic [RAD_W-1:0]          e_r;
    logic [IDX_W-1:0]          e_id;
    assign {e_x, e_y, e_r, e_id} = rd_reg;

    logic signed [COORD_W:0] dx, dy;
    assign dx = ({e_x[COORD_W-1], e_x} - {req_x_reg[COORD_W-1], req_x_reg});
    assign dy = ({e_y[COORD_W-1], e_y} - {req_y_reg[COORD_W-1], req_y_reg});

    logic [COORD_W:0]  ax_reg, ay_reg;
    logic [RAD_W:0]    rs_reg;
    logic              s1_v_reg, s1_kind_reg;
    logic [IDX_W-1:0]  s1_id_reg;

    // stage 2: squares
    logic [2*COORD_W+1:0] sx_reg, sy_reg;
    logic [2*RAD_W+1:0]   rr_reg;
    logic                 s2_v_reg, s2_kind_reg;
    logic [IDX_W-1:0]     s2_id_reg;

    // stage 3: compare result
    logic                 hit_reg, hit_kind_reg;
    logic [IDX_W-1:0]     hit_first_reg, hit_second_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            s1_v_reg <= cmd.test;
            s2_v_reg <= s1_v_reg;
            hit_reg  <= s2_v_reg &&
                        ({1'b0, sx_reg} + {1'b0, sy_reg} <= (2*COORD_W+3)'(rr_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg         <= dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
        ay_reg         <= dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);
        rs_reg         <= {1'b0, e_r} + {1'b0, req_r_reg};
        s1_kind_reg    <= rd_kind_reg;
        s1_id_reg      <= e_id;
        sx_reg         <= ax_reg * ax_reg;
        sy_reg         <= ay_reg * ay_reg;
        rr_reg         <= rs_reg * rs_reg;
        s2_kind_reg    <= s1_kind_reg;
        s2_id_reg      <= s1_id_reg;
        hit_kind_reg   <= s2_kind_reg;
        hit_first_reg  <= (s2_kind_reg == PAIR_OBJECT) ? s2_id_reg : req_id_reg;
        hit_second_reg <= (s2_kind_reg == PAIR_OBJECT) ? req_id_reg : s2_id_reg;
    end

    assign hit        = hit_reg;
    assign hit_kind   = hit_kind_reg;
    assign hit_first  = hit_first_reg;
    assign hit_second = hit_second_reg;

endmodule

// ===== rtl/cco_ctrl.sv =====
// ---------------------------------------------------------------------------
// cco_ctrl
// sequencer: accept, check, then for a kept object scan objects then particles, drain, store
// ---------------------------------------------------------------------------
module cco_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  cco_pkg::cco_stat_t stat,
    output cco_pkg::cco_cmd_t  cmd,
    output logic               busy
);
    import cco_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_OBJ   = 6'b000100,
        ST_PART  = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_STORE = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] drain_reg, drain_next;
    // test is asserted in the cycle after the read
    logic rd_d_reg;

    assign in_stall = (state_reg != ST_IDLE);
    assign busy     = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        drain_next = drain_reg;
        cmd        = '0;
        cmd.test   = rd_d_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = stat.keep_obj ? ST_OBJ : ST_IDLE;
            end
            ST_OBJ:
            begin
                if (stat.obj_done)
                begin
                    cmd.scan_clr = 1'b1;
                    state_next   = ST_PART;
                end
                else
                begin
                    cmd.rd_obj   = 1'b1;
                    cmd.scan_inc = 1'b1;
                end
            end
            ST_PART:
            begin
                if (stat.part_done)
                begin
                    drain_next = 2'd3;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.rd_part  = 1'b1;
                    cmd.scan_inc = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg - 2'd1;
                if (drain_reg == 2'd0)
                    state_next = ST_STORE;
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            drain_reg <= '0;
            rd_d_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= drain_next;
            rd_d_reg  <= cmd.rd_obj | cmd.rd_part;
        end
    end

endmodule

// ===== rtl/cco_pair_fifo.sv =====
// ---------------------------------------------------------------------------
// cco_pair_fifo
// pair queue with last marking, each pair held back one slot
// ---------------------------------------------------------------------------
module cco_pair_fifo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      hit,
    input  logic                      hit_kind,
    input  logic [cco_pkg::IDX_W-1:0] hit_first,
    input  logic [cco_pkg::IDX_W-1:0] hit_second,
    input  logic                      flush,
    output logic                      room,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      out_kind,
    output logic [cco_pkg::IDX_W-1:0] out_first,
    output logic [cco_pkg::IDX_W-1:0] out_second,
    output logic                      out_last
);
    import cco_pkg::*;

    localparam int DEPTH = 64;
    localparam int AW    = 6;
    localparam int EW    = 2*IDX_W + 2;

    // one pending pair waits until we know if it is the last one
    logic              hold_v_reg;
    logic [2*IDX_W:0]  hold_reg;

    logic [EW-1:0] mem [DEPTH];
    logic [AW:0]   wp_reg, rp_reg;
    logic          wr_en;
    logic [EW-1:0] wr_data;
    logic          pop;
    logic          fill;
    logic          out_v_reg;
    logic [EW-1:0] out_reg;

    assign wr_en   = hold_v_reg && (hit || flush);
    assign wr_data = {hold_reg, flush && !hit};
    assign pop     = out_v_reg && !out_stall;
    // refill the output register from the queue
    assign fill    = (wp_reg != rp_reg) && (!out_v_reg || pop);
    // a new run starts only with queue and output register empty
    assign room    = (wp_reg == rp_reg) && !out_v_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg[AW-1:0]] <= wr_data;
        if (hit)
            hold_reg <= {hit_kind, hit_first, hit_second};
        if (fill)
            out_reg <= mem[rp_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_v_reg <= 1'b0;
            wp_reg     <= '0;
            rp_reg     <= '0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (hit)
                hold_v_reg <= 1'b1;
            else if (flush)
                hold_v_reg <= 1'b0;
            if (wr_en)
                wp_reg <= wp_reg + (AW+1)'(1);
            if (fill)
                rp_reg <= rp_reg + (AW+1)'(1);
            if (fill)
                out_v_reg <= 1'b1;
            else if (pop)
                out_v_reg <= 1'b0;
        end
    end

    assign out_valid = out_v_reg;
    assign {out_kind, out_first, out_second, out_last} = out_reg;

endmodule

// ===== rtl/culled_circle_overlap_pairs.sv =====
// ---------------------------------------------------------------------------
// culled_circle_overlap_pairs
// view culling and broad phase overlap pairs over stored objects/particles
// ---------------------------------------------------------------------------
// sequence: a culled request or a particle ends after the check state; an object
//   is scanned against the n stored objects and m stored particles, the pipeline
//   drains, the object is stored, and its last pair is offered after that store
// throughput: one request at a time; the store scan (one entry a cycle) sets it
// new requests also wait until all pairs of the previous one are taken
// reset: asynchronous active low, clears counts, view box opens fully
module culled_circle_overlap_pairs #(
    parameter int OBJECT_SLOTS   = 32,
    parameter int PARTICLE_SLOTS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cco_pkg::CFG_ADDR_W-1:0]      cfg_index,
    input  logic signed [cco_pkg::COORD_W-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                start_frame,
    input  logic                                kind,
    input  logic [cco_pkg::IDX_W-1:0]           entity_index,
    input  logic signed [cco_pkg::COORD_W-1:0]  pos_x,
    input  logic signed [cco_pkg::COORD_W-1:0]  pos_y,
    input  logic [cco_pkg::RAD_W-1:0]           radius,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                pair_kind,
    output logic [cco_pkg::IDX_W-1:0]           first_index,
    output logic [cco_pkg::IDX_W-1:0]           second_index,
    output logic                                last_of_run
);
    import cco_pkg::*;

    cco_cmd_t          cmd;
    cco_stat_t         stat;
    logic              ctrl_stall, busy, room;
    logic              hit, hit_kind;
    logic [IDX_W-1:0]  hit_first, hit_second;
    logic              flush;

    assign cfg_ready = !busy;
    assign in_stall  = ctrl_stall || !room;

    // flush the held pair once the scan has drained
    assign flush = cmd.store;

    cco_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid && room),
        .in_stall (ctrl_stall),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    cco_datapath #(
        .OBJECT_SLOTS   (OBJECT_SLOTS),
        .PARTICLE_SLOTS (PARTICLE_SLOTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_addr       (cfg_index),
        .cfg_data       (cfg_data),
        .in_start_frame (start_frame),
        .in_kind        (kind),
        .in_index       (entity_index),
        .in_x           (pos_x),
        .in_y           (pos_y),
        .in_r           (radius),
        .hit            (hit),
        .hit_kind       (hit_kind),
        .hit_first      (hit_first),
        .hit_second     (hit_second)
    );

    cco_pair_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .hit        (hit),
        .hit_kind   (hit_kind),
        .hit_first  (hit_first),
        .hit_second (hit_second),
        .flush      (flush),
        .room       (room),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_kind   (pair_kind),
        .out_first  (first_index),
        .out_second (second_index),
        .out_last   (last_of_run)
    );

endmodule

// ===== rtl/cco_checker.sv =====
// ---------------------------------------------------------------------------
// cco_checker
// port level checks for the overlap pair block
// ---------------------------------------------------------------------------
module cco_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic last_of_run,
    input logic [15:0] first_index
);
    // no new request while pairs are still waiting
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request taken while pairs pending");

    // accepted request blocks the next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("back to back request taken");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(first_index)
                                      && $stable(last_of_run)))
        else $error("stalled pair changed");

endmodule

bind culled_circle_overlap_pairs cco_checker u_cco_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .last_of_run (last_of_run),
    .first_index (first_index)
);
